@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the plotter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/rcpp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpp_pkg
// Types, constants and trig helpers for the rotated circle point plotter.
// ----------------------------------------------------------------------------
package rcpp_pkg;

    // command codes
    typedef enum logic [1:0] {
        OP_CIRCLE = 2'd0,
        OP_ORBIT  = 2'd1,
        OP_AXIS   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTER_ROW  = 2'd0;
    localparam logic [1:0] CFG_CENTER_COL  = 2'd1;
    localparam logic [1:0] CFG_YAW_ANGLE   = 2'd2;
    localparam logic [1:0] CFG_TUBE_RADIUS = 2'd3;

    localparam int CFG_DATA_W = 9;

    // points per command, minus one
    localparam logic [5:0] CIRCLE_LAST_K = 6'd35;
    localparam logic [5:0] ORBIT_LAST_K  = 6'd8;
    localparam logic [5:0] AXIS_LAST_K   = 6'd15;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ISSUE,
        SEQ_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [8:0] pitch_angle;
        logic [8:0] roll_angle;
        logic [6:0] radius;
        logic [8:0] orbit_angle;
        logic [7:0] color;
    } cmd_t;

    typedef struct packed {
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
        logic        last;
    } pix_t;

    // quarter-wave sine, Q1.7
    localparam logic [7:0] QSIN [0:90] = '{
        8'h00,8'h02,8'h04,8'h07,8'h09,8'h0b,8'h0d,8'h10,8'h12,8'h14,
        8'h16,8'h18,8'h1b,8'h1d,8'h1f,8'h21,8'h23,8'h25,8'h28,8'h2a,
        8'h2c,8'h2e,8'h30,8'h32,8'h34,8'h36,8'h38,8'h3a,8'h3c,8'h3e,
        8'h40,8'h42,8'h44,8'h46,8'h48,8'h49,8'h4b,8'h4d,8'h4f,8'h51,
        8'h52,8'h54,8'h56,8'h57,8'h59,8'h5a,8'h5c,8'h5e,8'h5f,8'h61,
        8'h62,8'h63,8'h65,8'h66,8'h68,8'h69,8'h6a,8'h6b,8'h6d,8'h6e,
        8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,
        8'h78,8'h79,8'h7a,8'h7a,8'h7b,8'h7c,8'h7c,8'h7d,8'h7d,8'h7e,
        8'h7e,8'h7e,8'h7f,8'h7f,8'h7f,8'h7f,8'h80,8'h80,8'h80,8'h80,
        8'h80
    };

    // angles above 360 lose one full turn
    function automatic logic [8:0] fold_angle(input logic [8:0] a);
        return (a > 9'd360) ? (a - 9'd360) : a;
    endfunction

    function automatic logic signed [8:0] sin_deg(input logic [8:0] d);
        logic [6:0] idx;
        logic       neg;
        logic [8:0] mag;
        if (d <= 9'd90) begin
            idx = d[6:0];
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            idx = 7'(9'd180 - d);
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            idx = 7'(d - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(9'd360 - d);
            neg = 1'b1;
        end
        mag = {1'b0, QSIN[idx]};
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [8:0] cos_deg(input logic [8:0] d);
        logic [6:0] idx;
        logic       neg;
        logic [8:0] mag;
        if (d <= 9'd90) begin
            idx = 7'(9'd90 - d);
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            idx = 7'(d - 9'd90);
            neg = 1'b1;
        end else if (d <= 9'd270) begin
            idx = 7'(9'd270 - d);
            neg = 1'b1;
        end else begin
            idx = 7'(d - 9'd270);
            neg = 1'b0;
        end
        mag = {1'b0, QSIN[idx]};
        return neg ? -mag : mag;
    endfunction

    // wrapping 16-bit product of a Q1.7 factor and a 16-bit value
    function automatic logic signed [15:0] mul16(input logic signed [8:0]  a,
                                                 input logic signed [15:0] b);
        logic signed [24:0] p;
        p = a * b;
        return p[15:0];
    endfunction

    function automatic logic signed [15:0] asr7(input logic signed [15:0] v);
        return v >>> 7;
    endfunction

endpackage

@@ hw/rtl/rotated_circle_point_plotter_core.sv @@
// ----------------------------------------------------------------------------
// rotated_circle_point_plotter_core
// Turns one draw command into a run of rotated, screen-offset pixel writes.
// ----------------------------------------------------------------------------
//  channel | signals                          | role
//  cmd     | cmd_valid, cmd_stall, cmd        | draw command in
//  pix     | pix_valid, pix_stall, pix        | pixel writes out, last flagged
//  cfg     | cfg_write, cfg_index, cfg_data   | register writes
//
// A command issues its point count (36, 9 or 16): one point enters the
// six-stage multiply pipeline per cycle unless pix stalls, and the command
// register is held until the last point has left, so cmd_stall is high from
// drawing command acceptance to the last pixel transaction. A stall on pix
// freezes the whole pipeline. rst_n clears control state, loads register defaults.
// ----------------------------------------------------------------------------
module rotated_circle_point_plotter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  rcpp_pkg::cmd_t                   cmd,
    output logic                             pix_valid,
    input  logic                             pix_stall,
    output rcpp_pkg::pix_t                   pix,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [rcpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcpp_pkg::*;

    // configuration registers
    logic [7:0] center_row_reg, center_col_reg;
    logic [8:0] yaw_angle_reg;
    logic [2:0] tube_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg  <= 8'd120;
            center_col_reg  <= 8'd128;
            yaw_angle_reg   <= 9'd0;
            tube_radius_reg <= 3'd5;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CENTER_ROW:  center_row_reg  <= cfg_data[7:0];
                CFG_CENTER_COL:  center_col_reg  <= cfg_data[7:0];
                CFG_YAW_ANGLE:   yaw_angle_reg   <= cfg_data[8:0];
                CFG_TUBE_RADIUS: tube_radius_reg <= cfg_data[2:0];
                default:         center_row_reg  <= center_row_reg;
            endcase
        end
    end

    // sequencer
    seq_state_t state_reg, state_next;
    logic [5:0] k_reg, k_next;
    op_t        op_reg;
    logic       adv;
    logic       cmd_take;
    logic       last_k;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign adv      = !pix_valid || !pix_stall;

    always_comb
    begin
        unique case (op_reg)
            OP_CIRCLE: last_k = (k_reg == CIRCLE_LAST_K);
            OP_ORBIT:  last_k = (k_reg == ORBIT_LAST_K);
            OP_AXIS:   last_k = (k_reg == AXIS_LAST_K);
            OP_NONE:   last_k = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                k_next = 6'd0;
                if (cmd_valid && (op_t'(cmd.operation) != OP_NONE))
                    state_next = SEQ_ISSUE;
            end
            SEQ_ISSUE:
            begin
                if (adv)
                begin
                    if (last_k)
                        state_next = SEQ_DRAIN;
                    else
                        k_next = k_reg + 6'd1;
                end
            end
            SEQ_DRAIN:
            begin
                if (pix_valid && !pix_stall && pix.last)
                    state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    logic issue;
    always_comb
    begin
        cmd_stall = (state_reg != SEQ_IDLE);
        issue     = (state_reg == SEQ_ISSUE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            k_reg     <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // command register: trig of all angles taken at acceptance
    logic signed [8:0] s1_reg, c1_reg, s2_reg, c2_reg, s3_reg, c3_reg, s4_reg, c4_reg;
    logic [6:0]        radius_reg;
    logic [2:0]        rr_reg;
    logic [7:0]        color_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg     <= op_t'(cmd.operation);
            s1_reg     <= sin_deg(fold_angle(cmd.pitch_angle));
            c1_reg     <= cos_deg(fold_angle(cmd.pitch_angle));
            s2_reg     <= sin_deg(fold_angle(yaw_angle_reg));
            c2_reg     <= cos_deg(fold_angle(yaw_angle_reg));
            s3_reg     <= sin_deg(fold_angle(cmd.roll_angle));
            c3_reg     <= cos_deg(fold_angle(cmd.roll_angle));
            s4_reg     <= sin_deg(fold_angle(cmd.orbit_angle));
            c4_reg     <= cos_deg(fold_angle(cmd.orbit_angle));
            radius_reg <= cmd.radius;
            rr_reg     <= tube_radius_reg;
            color_reg  <= cmd.color;
        end
    end

    // stage 1: phase point scaled by radius (tube radius for orbit), or the axis ramp for axis
    logic [8:0]         phase;
    logic signed [15:0] amp, z_axis;
    logic signed [15:0] ma_next, mb_next;
    logic signed [15:0] ma_reg, mb_reg;
    logic               v1_reg, l1_reg;

    always_comb
    begin
        phase   = (op_reg == OP_ORBIT) ? (9'(k_reg) * 9'd40) : (9'(k_reg) * 9'd10);
        amp     = (op_reg == OP_ORBIT) ? 16'({13'd0, rr_reg}) : 16'({9'd0, radius_reg});
        z_axis  = 16'hffe0 + {8'd0, k_reg, 2'b00};
        ma_next = asr7(mul16(cos_deg(phase), amp));
        mb_next = asr7(mul16(sin_deg(phase), amp));
        if (op_reg == OP_AXIS)
            ma_next = z_axis;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            l1_reg <= last_k;
        end
    end

    // stage 2: orbit ring placement, gives X, Y', Z
    logic signed [15:0] t_sum;
    logic signed [15:0] x2_next, yp2_next, z2_next;
    logic signed [15:0] x2_reg, yp2_reg, z2_reg;
    logic               v2_reg, l2_reg;

    always_comb
    begin
        t_sum = 16'({9'd0, radius_reg}) + mb_reg;
        unique case (op_reg)
            OP_ORBIT:
            begin
                x2_next  = asr7(mul16(c4_reg, t_sum));
                yp2_next = asr7(mul16(s4_reg, t_sum));
                z2_next  = ma_reg;
            end
            OP_AXIS:
            begin
                x2_next  = 16'sd0;
                yp2_next = 16'sd0;
                z2_next  = ma_reg;
            end
            default:
            begin
                x2_next  = ma_reg;
                yp2_next = mb_reg;
                z2_next  = 16'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2_reg  <= x2_next;
            yp2_reg <= yp2_next;
            z2_reg  <= z2_next;
            l2_reg  <= l1_reg;
        end
    end

    // stage 3: pitch products
    logic signed [15:0] p1_reg, p2_reg, p3_reg, p4_reg, x3_reg;
    logic               v3_reg, l3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= mul16(c1_reg, yp2_reg);
            p2_reg <= mul16(s1_reg, z2_reg);
            p3_reg <= mul16(s1_reg, yp2_reg);
            p4_reg <= mul16(c1_reg, z2_reg);
            x3_reg <= x2_reg;
            l3_reg <= l2_reg;
        end
    end

    // stage 4: pitch sums, yaw products
    logic signed [15:0] y4_next, zp4_next;
    logic signed [15:0] p5_reg, p6_reg, y4_reg;
    logic               v4_reg, l4_reg;

    assign y4_next  = asr7(p1_reg - p2_reg);
    assign zp4_next = asr7(p3_reg + p4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_reg <= mul16(s2_reg, zp4_next);
            p6_reg <= mul16(c2_reg, x3_reg);
            y4_reg <= y4_next;
            l4_reg <= l3_reg;
        end
    end

    // stage 5: yaw sum, roll products
    logic signed [15:0] xp5_next;
    logic signed [15:0] q1_reg, q2_reg, q3_reg, q4_reg;
    logic               v5_reg, l5_reg;

    assign xp5_next = asr7(p5_reg + p6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg <= mul16(c3_reg, xp5_next);
            q2_reg <= mul16(s3_reg, y4_reg);
            q3_reg <= mul16(s3_reg, xp5_next);
            q4_reg <= mul16(c3_reg, y4_reg);
            l5_reg <= l4_reg;
        end
    end

    // stage 6: roll sums, screen offset, address pack
    logic signed [15:0] xf, yf;
    logic [7:0]         row, col;
    pix_t               pix_next;
    logic               pix_valid_reg;
    pix_t               pix_reg;

    always_comb
    begin
        xf  = asr7(q1_reg - q2_reg);
        yf  = asr7(q3_reg + q4_reg);
        row = center_row_reg - yf[7:0];
        col = center_col_reg + xf[7:0];
        pix_next.pixel_address = {row, col};
        pix_next.pixel_value   = color_reg;
        pix_next.last          = l5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (adv)
            pix_valid_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

@@ hw/rtl/rcpp_checker.sv @@
// ----------------------------------------------------------------------------
// rcpp_checker
// Port-level checks on the plotter core, bound to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcpp_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_stall,
    input rcpp_pkg::cmd_t   cmd,
    input logic             pix_valid,
    input logic             pix_stall,
    input rcpp_pkg::pix_t   pix
);
    import rcpp_pkg::*;

    // a taken drawing command blocks the input
    `ASSERT_NEXT(a_busy_after_cmd, clk, rst_n, cmd_valid && !cmd_stall && (op_t'(cmd.operation) != OP_NONE), cmd_stall)

    // nothing comes out while the block is idle
    `ASSERT_SAME(a_idle_no_pix, clk, rst_n, !cmd_stall, !pix_valid)

    // the last pixel transaction frees the input
    `ASSERT_NEXT(a_free_after_last, clk, rst_n, pix_valid && !pix_stall && pix.last, !cmd_stall)

    // a stalled pixel holds
    `ASSERT_NEXT(a_pix_hold, clk, rst_n, pix_valid && pix_stall, pix_valid && $stable(pix))

endmodule

bind rotated_circle_point_plotter_core rcpp_checker u_rcpp_checker (.*);
